[rtl/core/disk_head_scan_scheduler_unit_assert.svh]
// ----------------------------------------------------------------------------
// Assertion macros for the disk head scan scheduler
// Immediate-implication and next-cycle-implication checks on one clock.
// ----------------------------------------------------------------------------
`ifndef DISK_HEAD_SCAN_SCHEDULER_UNIT_ASSERT_SVH
`define DISK_HEAD_SCAN_SCHEDULER_UNIT_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define DHS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dhs assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define DHS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dhs assertion failed");

`endif

[rtl/core/dhs_pkg.sv]
// ----------------------------------------------------------------------------
// dhs_pkg
// Shared types and constants of the disk head scan scheduler.
// ----------------------------------------------------------------------------
package dhs_pkg;

    localparam int MAX_REQUESTS_DEF = 32;
    localparam int CYL_BITS_DEF     = 16;
    localparam int REQ_W            = 16;
    localparam int MOVE_W           = 17;
    localparam int SIZE_W           = 17;
    localparam int CFG_ADDR_W       = 2;
    localparam int CFG_DATA_W       = 17;
    localparam int OUT_TDATA_W      = 40;

    localparam logic [CFG_ADDR_W-1:0] REG_DISK_SIZE  = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_HEAD_START = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_POLICY     = 2'd2;

    localparam logic [SIZE_W-1:0] DISK_SIZE_RST = 17'd200;

    typedef enum logic [1:0] {
        POL_SCAN  = 2'd0,
        POL_CSCAN = 2'd1,
        POL_LOOK  = 2'd2,
        POL_CLOOK = 2'd3
    } t_policy;

    typedef enum logic [1:0] {
        ST_LOAD,
        ST_ROTATE,
        ST_CALC,
        ST_EMIT
    } t_state;

    // Per-cycle command broadcast to every cell of the chain.
    typedef struct packed {
        logic ins;   // sorted insert of the incoming request
        logic rot;   // rotate toward cell 0, wrap into the boundary cell
        logic shl;   // plain shift toward cell 0
    } t_cell_ctl;

endpackage

[rtl/core/disk_head_scan_scheduler_unit.sv]
// ----------------------------------------------------------------------------
// disk_head_scan_scheduler_unit
// Disk head scheduler (SCAN, C-SCAN, LOOK, C-LOOK) over a sorted cell chain.
// ----------------------------------------------------------------------------
// Requests stream in one per cycle while loading and are insertion-sorted
// into a chain of MAX_REQUESTS cells; the request flagged tlast closes the
// batch. The chain then rotates once per request below the head, so that
// the upper group sits at cell 0 and the lower group sits behind it in the
// policy's order; the CALC state works out the head travel; then one result
// leaves per cycle from cell 0 through the output register while the output
// is not stalled, the last one with tlast and the total movement. No request
// is taken until the last result is registered. Requests past MAX_REQUESTS
// are dropped and flagged on every result of that batch.
// ----------------------------------------------------------------------------
`include "disk_head_scan_scheduler_unit_assert.svh"

module disk_head_scan_scheduler_unit #(
    parameter int MAX_REQUESTS = dhs_pkg::MAX_REQUESTS_DEF,
    parameter int CYL_BITS     = dhs_pkg::CYL_BITS_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // configuration write channel
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [dhs_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [dhs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    // request stream
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    input  logic [dhs_pkg::REQ_W-1:0]          i_s_tdata,  // [15:0] request_cylinder
    input  logic                               i_s_tlast,  // final_request
    // result stream
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // [15:0] served_cylinder, [32:16] total_movement, [33] dropped, [39:34] zero
    output logic [dhs_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    output logic                               o_m_tlast   // run_end
);

    localparam int CNT_W = $clog2(MAX_REQUESTS + 1);
    localparam int IDX_W = (MAX_REQUESTS > 1) ? $clog2(MAX_REQUESTS) : 1;
    localparam int MW    = dhs_pkg::MOVE_W;
    localparam logic [dhs_pkg::SIZE_W-1:0] SIZE_CAP = dhs_pkg::SIZE_W'(2 ** CYL_BITS);

    function automatic logic [CYL_BITS-1:0] f_clamp(input logic [CYL_BITS-1:0] v,
                                                    input logic [CYL_BITS-1:0] t);
        return (v > t) ? t : v;
    endfunction

    // configuration
    logic [dhs_pkg::SIZE_W-1:0] r_disk_size;
    logic [dhs_pkg::REQ_W-1:0]  r_head_start;
    dhs_pkg::t_policy           r_policy;

    // control
    dhs_pkg::t_state   r_state, n_state;
    dhs_pkg::t_cell_ctl w_ctl;
    logic [CNT_W-1:0]  r_count;
    logic [CNT_W-1:0]  r_idx;
    logic [IDX_W-1:0]  r_bnd;
    logic              r_ovf;

    // datapath
    logic [CYL_BITS-1:0] r_max, r_min, r_vlb;
    logic [MW-1:0]       r_move;
    logic                r_out_valid;
    logic [dhs_pkg::REQ_W-1:0] r_out_cyl;
    logic [MW-1:0]       r_out_move;
    logic                r_out_drop;
    logic                r_out_last;

    logic [CYL_BITS-1:0] w_val [MAX_REQUESTS];
    logic                w_gt  [MAX_REQUESTS];

    logic [dhs_pkg::SIZE_W-1:0] w_top_full;
    logic [CYL_BITS-1:0] w_top, w_head, w_req, w_c0, w_vmax, w_vmin;
    logic [MW-1:0]       w_move, w_pos;
    logic w_in_acc, w_full, w_rot_go, w_out_free, w_last, w_lows_nz, w_ups;
    logic w_mirror;

    assign o_cfg_ready = 1'b1;

    // clamp the disk size into 1..2^CYL_BITS and take the top cylinder
    always_comb begin
        if (r_disk_size == '0) begin
            w_top_full = '0;
        end else if (r_disk_size > SIZE_CAP) begin
            w_top_full = SIZE_CAP - dhs_pkg::SIZE_W'(1);
        end else begin
            w_top_full = r_disk_size - dhs_pkg::SIZE_W'(1);
        end
    end

    assign w_top    = w_top_full[CYL_BITS-1:0];
    assign w_head   = f_clamp(r_head_start[CYL_BITS-1:0], w_top);
    assign w_req    = i_s_tdata[CYL_BITS-1:0];
    assign w_c0     = f_clamp(w_val[0], w_top);
    assign w_vmax   = f_clamp(r_max, w_top);
    assign w_vmin   = f_clamp(r_min, w_top);
    assign w_full   = r_count == CNT_W'(MAX_REQUESTS);
    assign w_in_acc = i_s_tvalid && o_s_tready;
    assign w_rot_go = (r_idx != r_count) && (w_c0 < w_head);
    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_last   = (r_idx + CNT_W'(1)) == r_count;
    assign w_lows_nz = r_idx != '0;
    assign w_ups    = r_idx != r_count;
    // SCAN and LOOK serve the lower group descending: reverse it while rotating
    assign w_mirror = (r_policy == dhs_pkg::POL_SCAN) || (r_policy == dhs_pkg::POL_LOOK);

    // chain of cells
    for (genvar g = 0; g < MAX_REQUESTS; g++) begin : g_cell
        logic [CYL_BITS-1:0] w_lv, w_rv;
        logic                w_lg;

        if (g == 0) begin : g_first
            assign w_lv = '0;
            assign w_lg = 1'b0;
        end else begin : g_inner
            assign w_lv = w_val[g-1];
            assign w_lg = w_gt[g-1];
        end

        if (g == MAX_REQUESTS - 1) begin : g_tail
            assign w_rv = '0;
        end else begin : g_body
            assign w_rv = w_val[g+1];
        end

        dhs_cell #(
            .DATA_W (CYL_BITS),
            .CNT_W  (CNT_W),
            .IDX_W  (IDX_W),
            .IDX    (g)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctl       (w_ctl),
            .i_req       (w_req),
            .i_count     (r_count),
            .i_bnd       (r_bnd),
            .i_left_val  (w_lv),
            .i_left_gt   (w_lg),
            .i_right_val (w_rv),
            .i_head_val  (w_val[0]),
            .o_val       (w_val[g]),
            .o_gt        (w_gt[g])
        );
    end

    // head travel, from min, max and the highest request below the head
    always_comb begin
        w_pos = w_ups ? MW'(w_vmax) : MW'(w_head);
        unique case (r_policy)
            dhs_pkg::POL_SCAN: begin
                w_move = w_lows_nz ? (MW'(w_top) - MW'(w_head)) + (MW'(w_top) - MW'(w_vmin))
                                   : MW'(w_vmax) - MW'(w_head);
            end
            dhs_pkg::POL_CSCAN: begin
                w_move = w_lows_nz ? (MW'(w_top) - MW'(w_head)) + MW'(r_vlb)
                                   : MW'(w_vmax) - MW'(w_head);
            end
            dhs_pkg::POL_LOOK: begin
                w_move = (w_pos - MW'(w_head)) + (w_lows_nz ? w_pos - MW'(w_vmin) : '0);
            end
            dhs_pkg::POL_CLOOK: begin
                w_move = (w_ups ? MW'(w_vmax) - MW'(w_head) : '0) +
                         (w_lows_nz ? MW'(r_vlb) - MW'(w_vmin) : '0);
            end
            default: begin
                w_move = '0;
            end
        endcase
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dhs_pkg::ST_LOAD: begin
                if (w_in_acc && i_s_tlast) begin
                    n_state = dhs_pkg::ST_ROTATE;
                end
            end
            dhs_pkg::ST_ROTATE: begin
                if (!w_rot_go) begin
                    n_state = dhs_pkg::ST_CALC;
                end
            end
            dhs_pkg::ST_CALC: begin
                n_state = dhs_pkg::ST_EMIT;
            end
            dhs_pkg::ST_EMIT: begin
                if (w_out_free && w_last) begin
                    n_state = dhs_pkg::ST_LOAD;
                end
            end
            default: begin
                n_state = dhs_pkg::ST_LOAD;
            end
        endcase
    end

    // state outputs
    always_comb begin
        o_s_tready = r_state == dhs_pkg::ST_LOAD;
        w_ctl.ins  = w_in_acc && !w_full;
        w_ctl.rot  = (r_state == dhs_pkg::ST_ROTATE) && w_rot_go;
        w_ctl.shl  = (r_state == dhs_pkg::ST_EMIT) && w_out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dhs_pkg::ST_LOAD;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_disk_size  <= dhs_pkg::DISK_SIZE_RST;
            r_head_start <= '0;
            r_policy     <= dhs_pkg::POL_SCAN;
            r_count      <= '0;
            r_idx        <= '0;
            r_bnd        <= '0;
            r_ovf        <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_addr)
                    dhs_pkg::REG_DISK_SIZE:  r_disk_size  <= i_cfg_data;
                    dhs_pkg::REG_HEAD_START: r_head_start <= i_cfg_data[dhs_pkg::REQ_W-1:0];
                    dhs_pkg::REG_POLICY:     r_policy     <= dhs_pkg::t_policy'(i_cfg_data[1:0]);
                    default: begin
                    end
                endcase
            end

            if (w_ctl.ins) begin
                r_count <= r_count + CNT_W'(1);
            end
            if (w_in_acc && w_full) begin
                r_ovf <= 1'b1;
            end
            // batch closed: rotation wraps into the last filled cell
            if (w_in_acc && i_s_tlast) begin
                r_idx <= '0;
                r_bnd <= w_ctl.ins ? IDX_W'(r_count) : IDX_W'(r_count - CNT_W'(1));
            end

            if (w_ctl.rot) begin
                r_idx <= r_idx + CNT_W'(1);
                if (w_mirror) begin
                    r_bnd <= r_bnd - IDX_W'(1);
                end
            end

            if (r_state == dhs_pkg::ST_CALC) begin
                r_idx <= '0;
            end

            if (w_ctl.shl) begin
                r_out_valid <= 1'b1;
                r_idx       <= r_idx + CNT_W'(1);
                if (w_last) begin
                    r_count <= '0;
                    r_ovf   <= 1'b0;
                end
            end else if (i_m_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_ctl.ins) begin
            if (r_count == '0) begin
                r_max <= w_req;
                r_min <= w_req;
            end else begin
                if (w_req > r_max) begin
                    r_max <= w_req;
                end
                if (w_req < r_min) begin
                    r_min <= w_req;
                end
            end
        end
        if (w_ctl.rot) begin
            r_vlb <= w_c0;
        end
        if (r_state == dhs_pkg::ST_CALC) begin
            r_move <= w_move;
        end
        if (w_ctl.shl) begin
            r_out_cyl  <= dhs_pkg::REQ_W'(w_c0);
            r_out_move <= w_last ? r_move : '0;
            r_out_drop <= r_ovf;
            r_out_last <= w_last;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tlast  = r_out_last;
    assign o_m_tdata  = dhs_pkg::OUT_TDATA_W'({r_out_drop, r_out_move, r_out_cyl});

    `DHS_ASSERT_NEXT(a_final_starts_rotate, i_clk, i_rst_n, w_in_acc && i_s_tlast, r_state == dhs_pkg::ST_ROTATE)
    `DHS_ASSERT_NOW(a_rotate_in_range, i_clk, i_rst_n, r_state == dhs_pkg::ST_ROTATE, r_idx <= r_count)
    `DHS_ASSERT_NOW(a_emit_in_range, i_clk, i_rst_n, r_state == dhs_pkg::ST_EMIT, r_idx < r_count)
    `DHS_ASSERT_NOW(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(MAX_REQUESTS))

endmodule

[rtl/core/dhs_cell.sv]
// ----------------------------------------------------------------------------
// dhs_cell
// One slot of the sorted request chain: insert, rotate and shift.
// ----------------------------------------------------------------------------
module dhs_cell #(
    parameter int DATA_W = dhs_pkg::CYL_BITS_DEF,
    parameter int CNT_W  = 6,
    parameter int IDX_W  = 5,
    parameter int IDX    = 0
) (
    input  logic                i_clk,
    input  dhs_pkg::t_cell_ctl  i_ctl,
    input  logic [DATA_W-1:0]   i_req,
    input  logic [CNT_W-1:0]    i_count,
    input  logic [IDX_W-1:0]    i_bnd,
    input  logic [DATA_W-1:0]   i_left_val,
    input  logic                i_left_gt,
    input  logic [DATA_W-1:0]   i_right_val,
    input  logic [DATA_W-1:0]   i_head_val,
    output logic [DATA_W-1:0]   o_val,
    output logic                o_gt
);

    logic [DATA_W-1:0] r_val;
    logic              w_filled;

    assign w_filled = i_count > CNT_W'(IDX);
    // An empty slot counts as above any request, so the gt pattern stays 0..01..1.
    assign o_gt  = !w_filled || (r_val > i_req);
    assign o_val = r_val;

    always_ff @(posedge i_clk) begin
        priority if (i_ctl.ins) begin
            if (o_gt) begin
                r_val <= i_left_gt ? i_left_val : i_req;
            end
        end else if (i_ctl.rot) begin
            if (IDX_W'(IDX) < i_bnd) begin
                r_val <= i_right_val;
            end else if (IDX_W'(IDX) == i_bnd) begin
                r_val <= i_head_val;
            end
        end else if (i_ctl.shl) begin
            r_val <= i_right_val;
        end
    end

endmodule

[test/tb_top.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: disk head scan scheduler testbench
// Streams cylinder request batches under all four scan policies and several
// geometries, predicts the service order and head travel of every batch, and
// checks each result field against it. Both stream sides idle at random.
// ----------------------------------------------------------------------------

class seek_order_book;

    typedef struct {
        logic [15:0] served;
        logic [16:0] move;
        logic        dropped;
        logic        last;
    } t_served_item;

    logic [15:0]      pending_q[$];    // sorted pending requests
    logic             overflow;
    logic [16:0]      disk_cyls;
    logic [15:0]      head_cyl;
    dhs_pkg::t_policy pol;
    t_served_item     due_served[$];
    int               errors;

    function void reset_state();
        pending_q.delete();
        due_served.delete();
        overflow  = 1'b0;
        disk_cyls = dhs_pkg::DISK_SIZE_RST;
        head_cyl  = '0;
        pol       = dhs_pkg::POL_SCAN;
        errors    = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [16:0] val);
        case (idx)
            dhs_pkg::REG_DISK_SIZE:  disk_cyls = val;
            dhs_pkg::REG_HEAD_START: head_cyl = val[15:0];
            dhs_pkg::REG_POLICY:     pol = dhs_pkg::t_policy'(val[1:0]);
            default: ;
        endcase
    endfunction

    function void take_request(logic [15:0] cyl, logic fin);
        int unsigned  k, n, lows, size, top, h, pos, move;
        int unsigned  cyls[$];
        int unsigned  order[$];
        t_served_item r;
        if (pending_q.size() < dhs_pkg::MAX_REQUESTS_DEF) begin
            k = pending_q.size();
            while (k > 0 && pending_q[k-1] > cyl) k--;
            pending_q.insert(k, cyl);
        end else begin
            overflow = 1'b1;
        end
        if (!fin) return;

        n = pending_q.size();
        size = disk_cyls;
        if (size == 0) size = 1;
        if (size > 65536) size = 65536;
        top = size - 1;
        h = head_cyl;
        if (h > top) h = top;
        lows = 0;
        foreach (pending_q[i]) begin
            cyls.push_back(pending_q[i] > top ? top : pending_q[i]);
            if (cyls[i] < h) lows++;
        end

        // upper group ascending first, then the lower group in policy order
        for (int i = lows; i < n; i++) order.push_back(cyls[i]);
        if (pol == dhs_pkg::POL_SCAN || pol == dhs_pkg::POL_LOOK) begin
            for (int i = int'(lows) - 1; i >= 0; i--) order.push_back(cyls[i]);
        end else begin
            for (int i = 0; i < lows; i++) order.push_back(cyls[i]);
        end

        if (n != 0) begin
            case (pol)
                dhs_pkg::POL_SCAN:
                    move = lows > 0 ? (top - h) + (top - cyls[0]) : cyls[n-1] - h;
                dhs_pkg::POL_CSCAN:
                    move = lows > 0 ? (top - h) + cyls[lows-1] : cyls[n-1] - h;
                dhs_pkg::POL_LOOK: begin
                    pos  = lows < n ? cyls[n-1] : h;
                    move = (pos - h) + (lows > 0 ? pos - cyls[0] : 0);
                end
                default:
                    move = (lows < n ? cyls[n-1] - h : 0) +
                           (lows > 0 ? cyls[lows-1] - cyls[0] : 0);
            endcase
            for (int i = 0; i < n; i++) begin
                r.served  = order[i][15:0];
                r.last    = (i == n - 1);
                r.move    = r.last ? move[16:0] : 17'd0;
                r.dropped = overflow;
                due_served.push_back(r);
            end
        end
        pending_q.delete();
        overflow = 1'b0;
    endfunction

    function void check_served(logic [dhs_pkg::OUT_TDATA_W-1:0] data, logic last);
        t_served_item r;
        if (due_served.size() == 0) begin
            $error("unexpected result: tdata %h tlast %b", data, last);
            errors++;
            return;
        end
        r = due_served.pop_front();
        if (data[15:0] !== r.served) begin
            $error("served_cylinder: expected %0d, got %0d", r.served, data[15:0]);
            errors++;
        end
        if (data[32:16] !== r.move) begin
            $error("total_movement: expected %0d, got %0d", r.move, data[32:16]);
            errors++;
        end
        if (data[33] !== r.dropped) begin
            $error("dropped: expected %0d, got %0d", r.dropped, data[33]);
            errors++;
        end
        if (data[39:34] !== 6'd0) begin
            $error("tdata padding: expected 0, got %0d", data[39:34]);
            errors++;
        end
        if (last !== r.last) begin
            $error("run_end: expected %0d, got %0d", r.last, last);
            errors++;
        end
    endfunction

endclass

module tb_top;

    localparam logic [dhs_pkg::CFG_ADDR_W-1:0] REG_UNUSED = 2'd3;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [dhs_pkg::CFG_ADDR_W-1:0]  i_cfg_addr = '0;
    logic [dhs_pkg::CFG_DATA_W-1:0]  i_cfg_data = '0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [dhs_pkg::REQ_W-1:0]       i_s_tdata = '0;
    logic                            i_s_tlast = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [dhs_pkg::OUT_TDATA_W-1:0] o_m_tdata;
    logic                            o_m_tlast;

    seek_order_book book;
    bit             steady = 1'b0;   // no idling on either side while set
    int             stall_left = 0;
    int             items_sent = 0;
    logic [16:0]    cur_size = 17'd200;
    logic [15:0]    cur_head = 16'd0;

    disk_head_scan_scheduler_unit u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tlast  (i_s_tlast),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tlast  (o_m_tlast)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 50) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 8);
        return $urandom_range(15, 40);
    endfunction

    // result side: random back-pressure
    always @(posedge i_clk) begin
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            i_m_tready <= 1'b0;
        end else if (!steady && $urandom_range(0, 3) == 0) begin
            stall_left <= pick_gap();
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_m_tvalid && i_m_tready) book.check_served(o_m_tdata, o_m_tlast);
    end

    // valid stays high after a handshake; the next call lowers it for a gap
    task automatic send_request(input logic [15:0] cyl, input logic fin);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= cyl;
        i_s_tlast  <= fin;
        do @(posedge i_clk); while (!o_s_tready);
        book.take_request(cyl, fin);
        items_sent++;
    endtask

    task automatic write_reg(input logic [dhs_pkg::CFG_ADDR_W-1:0] idx,
                             input logic [dhs_pkg::CFG_DATA_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        book.write_reg(idx, val);
    endtask

    // upper data bits are noise; the block keeps only the field width
    task automatic set_geometry(input logic [16:0] size, input logic [15:0] head,
                                input dhs_pkg::t_policy pol);
        logic [16:0] noise;
        noise = 17'($urandom);
        write_reg(dhs_pkg::REG_DISK_SIZE, size);
        write_reg(dhs_pkg::REG_HEAD_START, {noise[16], head});
        write_reg(dhs_pkg::REG_POLICY, {noise[16:2], pol});
        i_cfg_valid <= 1'b0;
        cur_size = size;
        cur_head = head;
    endtask

    // let the batch finish and the block settle back to loading
    task automatic drain_batch();
        i_s_tvalid <= 1'b0;
        while (book.due_served.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
    endtask

    task automatic run_batch(input int len);
        logic [15:0] cyl, prev;
        int          r, lim;
        prev = cur_head;
        lim  = (cur_size == 0) ? 0 : (cur_size > 65536 ? 65535 : cur_size - 1);
        for (int i = 0; i < len; i++) begin
            r = $urandom_range(0, 99);
            if (r < 10)      cyl = cur_head;
            else if (r < 20) cyl = prev;
            else if (r < 75) cyl = 16'($urandom_range(0, lim));
            else if (r < 85) cyl = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
            else             cyl = 16'($urandom);
            send_request(cyl, i == len - 1);
            prev = cyl;
        end
    endtask

    initial begin
        int          r, len, batches, wait_cnt;
        logic [16:0] size;
        logic [15:0] head;
        book = new();
        book.reset_state();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // reset geometry: saturation past the top cylinder and duplicates
        send_request(16'hFFFF, 1'b0);
        send_request(16'd0, 1'b0);
        send_request(16'd100, 1'b0);
        send_request(16'd100, 1'b1);
        drain_batch();
        write_reg(REG_UNUSED, 17'h1ABCD);

        // request at the head plus both groups, every policy
        for (int p = 0; p < 4; p++) begin
            if (p != 0) drain_batch();
            set_geometry(17'd200, 16'd53, dhs_pkg::t_policy'(p));
            send_request(16'd53, 1'b0);
            send_request(16'd98, 1'b0);
            send_request(16'd14, 1'b0);
            send_request(16'd183, 1'b1);
        end
        drain_batch();

        // nothing at or above the head
        set_geometry(17'd200, 16'd190, dhs_pkg::POL_CLOOK);
        send_request(16'd10, 1'b0);
        send_request(16'd5, 1'b1);
        drain_batch();

        // zero disk size and head far beyond it
        set_geometry(17'd0, 16'hFFFF, dhs_pkg::POL_CSCAN);
        send_request(16'd7, 1'b1);
        drain_batch();

        // oversize disk, both cylinder extremes
        set_geometry(17'h1FFFF, 16'hFFFF, dhs_pkg::POL_SCAN);
        send_request(16'd0, 1'b0);
        send_request(16'hFFFF, 1'b1);

        while (items_sent < 400) begin
            drain_batch();
            r = $urandom_range(0, 11);
            case (r)
                0: size = 17'd0;
                1: size = 17'd1;
                2: size = 17'd2;
                3: size = 17'd65536;
                4: size = 17'h1FFFF;
                5: size = 17'($urandom_range(0, 131071));
                6: size = 17'd65535;
                default: size = 17'($urandom_range(3, 400));
            endcase
            r = $urandom_range(0, 7);
            case (r)
                0: head = 16'd0;
                1: head = 16'hFFFF;
                2: head = (size == 0) ? 16'd0 : 16'(size - 1);
                3: head = 16'($urandom);
                default: head = 16'($urandom_range(0, 300));
            endcase
            set_geometry(size, head, dhs_pkg::t_policy'($urandom_range(0, 3)));
            steady  = ($urandom_range(0, 4) == 0);
            batches = $urandom_range(1, 4);
            for (int b = 0; b < batches; b++) begin
                r = $urandom_range(0, 99);
                if (r < 70)      len = $urandom_range(1, 8);
                else if (r < 88) len = $urandom_range(9, 31);
                else if (r < 94) len = dhs_pkg::MAX_REQUESTS_DEF;
                else             len = $urandom_range(33, 40);
                run_batch(len);
            end
        end

        i_s_tvalid <= 1'b0;
        wait_cnt = 0;
        while (book.due_served.size() != 0 && wait_cnt < 100000) begin
            @(posedge i_clk);
            wait_cnt++;
        end
        repeat (50) @(posedge i_clk);
        if (book.due_served.size() != 0) begin
            $error("%0d results never arrived", book.due_served.size());
            book.errors++;
        end
        if (book.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/dhs_pkg.sv
rtl/core/dhs_cell.sv
rtl/core/disk_head_scan_scheduler_unit.sv
test/tb_top.sv
